/* sv/q31div_pkg.sv */
// shared types and constants for the q31 series divider
package q31div_pkg;

	localparam int DATA_W        = 32;
	localparam int MAG_W         = 31;
	localparam int TERM_W        = 6;
	localparam int MUL_W         = 33;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int MAX_TERMS_DEF = 32;
	localparam int NORM_STEPS    = 5;
	localparam int STEP_W        = 3;
	localparam int SHIFT_W       = 5;

	localparam logic [TERM_W-1:0] TERM_RESET   = 6'd8;
	localparam logic [DATA_W-1:0] Q31_MAX      = 32'h7fffffff;
	localparam logic [DATA_W-1:0] Q31_MIN      = 32'h80000000;
	localparam logic [DATA_W-1:0] Q31_CLAMP    = 32'h80000001;
	localparam logic [MAG_W-1:0]  Q31_ONE      = 31'h7fffffff;
	localparam logic [SHIFT_W-1:0] FIRST_SHIFT = 5'd16;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_NORM  = 7'b0000100,
		ST_POW   = 7'b0001000,
		ST_ADD   = 7'b0010000,
		ST_MUL   = 7'b0100000,
		ST_SAT   = 7'b1000000
	} state_t;

endpackage

/* sv/q31div_mul.sv */
// shared signed multiplier for series powers and the final product
module q31div_mul
	import q31div_pkg::*;
(
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p
);

	assign p = PROD_W'(a) * PROD_W'(b);

endmodule

/* sv/q31_taylor_series_divider_top.sv */
// q31 divider by truncated geometric series, sequencer and datapath
//
// One division is accepted when start is high and busy is low. The quotient
// appears on quotient with done high for exactly one cycle; the receiver cannot
// stall it. A zero numerator or a magnitude ratio above one finishes straight
// from the check state to the done cycle. Otherwise an item passes through
// one check step, five normalize steps, one shared multiplier pass per extra
// series term, a closing add, the final multiply and the saturation step
// before the done cycle. The term count resets to 8. A new item may be started
// in the cycle done is high. The user must write term_count through cfg_we and
// cfg_wdata only while the block is idle; the block itself does not enforce it.
module q31_taylor_series_divider_top
	import q31div_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [TERM_W-1:0]        cfg_wdata,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] numerator,
	input  logic signed [DATA_W-1:0] denominator,
	output logic                     done,
	output logic signed [DATA_W-1:0] quotient
);

	localparam int CW = $clog2(MAX_TERMS + 1);

	state_t                    state_q;
	logic [TERM_W-1:0]         term_q;
	logic [CW-1:0]             cnt_q;
	logic [STEP_W-1:0]         step_q;
	logic signed [DATA_W-1:0]  num_q;
	logic [MAG_W-1:0]          den_q;
	logic [MAG_W-1:0]          pw_q;
	logic [DATA_W-1:0]         sum_q;
	logic signed [63:0]        prod_q;
	logic signed [DATA_W-1:0]  quot_q;
	logic                      done_q;

	logic signed [DATA_W-1:0]  num_c;
	logic signed [DATA_W-1:0]  den_c;
	logic [TERM_W:0]           term_ext;
	logic [TERM_W:0]           cnt_init;
	logic [DATA_W-1:0]         abs_n;
	logic [SHIFT_W-1:0]        sa;
	logic [MAG_W-1:0]          top_mask;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [32:0]        res_w;

	q31div_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	always_comb begin
		num_c = (numerator == Q31_MIN) ? Q31_CLAMP : numerator;
		den_c = (denominator == Q31_MIN) ? Q31_CLAMP : denominator;
		term_ext = {1'b0, term_q};
		if (term_q == '0) begin
			cnt_init = '0;
		end else if (term_ext > (TERM_W+1)'(MAX_TERMS)) begin
			cnt_init = (TERM_W+1)'(MAX_TERMS - 1);
		end else begin
			cnt_init = term_ext - 1'b1;
		end
		abs_n    = num_q[DATA_W-1] ? -num_q : num_q;
		sa       = FIRST_SHIFT >> step_q;
		top_mask = ~(Q31_ONE >> sa);
		if (state_q == ST_MUL) begin
			mul_a = {1'b0, sum_q};
			mul_b = {num_q[DATA_W-1], num_q};
		end else begin
			mul_a = {2'b00, pw_q};
			mul_b = {2'b00, ~den_q};
		end
		res_w = prod_q[63:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
		end else if (cfg_we) begin
			term_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= CW'(cnt_init);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					if (num_q == '0 || abs_n[MAG_W-1:0] > den_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(NORM_STEPS - 1)) begin
						state_q <= (cnt_q == '0) ? ST_ADD : ST_POW;
					end
				end
				ST_POW: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					if (den_c[DATA_W-1]) begin
						num_q <= -num_c;
						den_q <= MAG_W'(-den_c);
					end else begin
						num_q <= num_c;
						den_q <= den_c[MAG_W-1:0];
					end
				end
			end
			ST_CHECK: begin
				pw_q  <= Q31_ONE;
				sum_q <= '0;
				if (num_q == '0) begin
					quot_q <= '0;
				end else if (!num_q[DATA_W-1] && den_q != '0) begin
					quot_q <= Q31_MAX;
				end else begin
					quot_q <= Q31_MIN;
				end
			end
			ST_NORM: begin
				if ((den_q & top_mask) == '0) begin
					den_q <= den_q << sa;
					num_q <= num_q <<< sa;
				end
			end
			ST_POW: begin
				pw_q  <= mul_p[61:31];
				sum_q <= sum_q + {1'b0, pw_q};
			end
			ST_ADD: begin
				sum_q <= sum_q + {1'b0, pw_q};
			end
			ST_MUL: begin
				prod_q <= mul_p[63:0];
			end
			ST_SAT: begin
				if (res_w[32] != res_w[31]) begin
					quot_q <= res_w[32] ? Q31_MIN : Q31_MAX;
				end else begin
					quot_q <= res_w[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign quotient = quot_q;

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start");

endmodule
